>>> hw/rtl/jesc_pkg.sv
// Shared types, constants and saturating helpers for the Julia escape-time core.
// No dependencies; imported by every module of the core.
package jesc_pkg;

  localparam int PIX_BITS   = 12;
  localparam int CNT_BITS   = 12;
  localparam int COORD_BITS = 64;
  localparam int STEP_BITS  = 63;
  localparam int T_BITS     = 16;
  localparam int IDX_BITS   = 3;
  localparam int DIV_CNT_BITS = 4;

  localparam logic [COORD_BITS-1:0] S64_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] S64_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  // Register reset values
  localparam logic [COORD_BITS-1:0] CENTER_RE_RST = 64'hF4C5_974E_65BE_A0BA;
  localparam logic [COORD_BITS-1:0] CENTER_IM_RST = 64'hF9DA_5119_CE07_5F70;
  localparam logic [STEP_BITS-1:0]  STEP_RST      = 63'h000F_2B9D_6480_F2BA;
  localparam logic [CNT_BITS-1:0]   LIMIT_RST     = 12'd500;
  localparam logic [PIX_BITS-1:0]   WIDTH_RST     = 12'd1920;
  localparam logic [PIX_BITS-1:0]   HEIGHT_RST    = 12'd1080;

  // Colour gradient weights (9, 15, 8.5 times 255; blue scaled by two)
  localparam logic [11:0] RED_K   = 12'd2295;
  localparam logic [11:0] GREEN_K = 12'd3825;
  localparam logic [12:0] BLUE_K  = 13'd4335;

  typedef enum logic [IDX_BITS-1:0] {
    REG_CENTER_RE       = 3'd0,
    REG_CENTER_IM       = 3'd1,
    REG_PIXEL_STEP      = 3'd2,
    REG_ITERATION_LIMIT = 3'd3,
    REG_IMAGE_WIDTH     = 3'd4,
    REG_IMAGE_HEIGHT    = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START0,
    ST_START1,
    ST_PP,
    ST_SUM,
    ST_FIX,
    ST_TEST,
    ST_DIV,
    ST_COL0,
    ST_COL1,
    ST_COL2,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [PIX_BITS-1:0] pixel_x;
    logic [PIX_BITS-1:0] pixel_y;
  } pixel_in_t;

  typedef struct packed {
    logic [CNT_BITS-1:0] iteration_count;
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
  } pixel_out_t;

  typedef struct packed {
    logic load;
    logic start0;
    logic start1;
    logic mul_pp;
    logic mul_sum;
    logic mul_fix;
    logic update;
    logic div_init;
    logic div_step;
    logic col0;
    logic col1;
    logic col2;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic go_on;
    logic black;
  } dp_status_t;

  function automatic logic [COORD_BITS-1:0] sat_add64(input logic [COORD_BITS-1:0] a,
                                                      input logic [COORD_BITS-1:0] b);
    logic [COORD_BITS-1:0] r;
    r = a + b;
    if (!(a[COORD_BITS-1] ^ b[COORD_BITS-1]) && (a[COORD_BITS-1] ^ r[COORD_BITS-1]))
      return a[COORD_BITS-1] ? S64_MIN : S64_MAX;
    return r;
  endfunction

  function automatic logic [COORD_BITS-1:0] sat_sub64(input logic [COORD_BITS-1:0] a,
                                                      input logic [COORD_BITS-1:0] b);
    logic [COORD_BITS-1:0] r;
    r = a - b;
    if ((a[COORD_BITS-1] ^ b[COORD_BITS-1]) && (a[COORD_BITS-1] ^ r[COORD_BITS-1]))
      return a[COORD_BITS-1] ? S64_MIN : S64_MAX;
    return r;
  endfunction

  // Clamp a signed 128-bit value to the signed 64-bit range
  function automatic logic [COORD_BITS-1:0] sat_narrow(input logic [127:0] p);
    if ((&p[127:COORD_BITS-1]) || !(|p[127:COORD_BITS-1]))
      return p[COORD_BITS-1:0];
    return p[127] ? S64_MIN : S64_MAX;
  endfunction

endpackage

>>> hw/rtl/jesc_mul.sv
// Three-stage signed 64x64 multiplier built from four 32x32 partial products.
// Depends on jesc_pkg.
module jesc_mul (
  input  logic         clk_i,
  input  logic         pp_en_i,
  input  logic         sum_en_i,
  input  logic         fix_en_i,
  input  logic [63:0]  a_i,
  input  logic [63:0]  b_i,
  output logic [127:0] prod_o
);
  import jesc_pkg::*;

  logic [63:0]  p00_q, p01_q, p10_q, p11_q, corr_q;
  logic [127:0] sum_q, prod_q;

  // Form unsigned partial products and the signed correction term
  always_ff @(posedge clk_i) begin
    if (pp_en_i) begin
      p00_q  <= a_i[31:0]  * b_i[31:0];
      p01_q  <= a_i[31:0]  * b_i[63:32];
      p10_q  <= a_i[63:32] * b_i[31:0];
      p11_q  <= a_i[63:32] * b_i[63:32];
      corr_q <= (a_i[63] ? b_i : 64'd0) + (b_i[63] ? a_i : 64'd0);
    end
  end

  // Add partial products into the unsigned 128-bit product
  always_ff @(posedge clk_i) begin
    if (sum_en_i) begin
      sum_q <= {p11_q, p00_q} + {32'd0, p01_q, 32'd0} + {32'd0, p10_q, 32'd0};
    end
  end

  // Apply the two's complement correction to the upper half
  always_ff @(posedge clk_i) begin
    if (fix_en_i) begin
      prod_q <= {sum_q[127:64] - corr_q, sum_q[63:0]};
    end
  end

  assign prod_o = prod_q;

endmodule

>>> hw/rtl/jesc_datapath.sv
// Datapath: configuration registers, start point, z iteration, divider, colour.
// Depends on jesc_pkg and jesc_mul.
module jesc_datapath #(
  parameter int FRAC_BITS = 60
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [jesc_pkg::IDX_BITS-1:0] cfg_idx_i,
  input  logic [63:0]                   cfg_wdata_i,
  input  jesc_pkg::pixel_in_t           in_data_i,
  input  jesc_pkg::dp_cmd_t             cmd_i,
  output jesc_pkg::dp_status_t          status_o,
  output jesc_pkg::pixel_out_t          out_data_o
);
  import jesc_pkg::*;

  localparam logic [COORD_BITS-1:0] FOUR = 64'd1 << (FRAC_BITS + 2);

  logic [COORD_BITS-1:0] center_re_q, center_im_q;
  logic [STEP_BITS-1:0]  step_q;
  logic [CNT_BITS-1:0]   limit_q;
  logic [PIX_BITS-1:0]   width_q, height_q;

  logic [PIX_BITS:0]     off_x_q, off_y_q;
  logic signed [76:0]    sx_prod, sy_prod;
  logic [76:0]           sx_q, sy_q;
  logic [COORD_BITS-1:0] zx_q, zy_q;
  logic [CNT_BITS-1:0]   count_q;

  logic [127:0]          xx_prod, yy_prod, xy_prod;
  logic signed [127:0]   xx_sh, yy_sh, xy_sh;
  logic [COORD_BITS-1:0] xx, yy, xy, m2;

  logic [CNT_BITS-1:0]   rem_q;
  logic [CNT_BITS:0]     trial;
  logic [T_BITS-1:0]     quo_q;
  logic [T_BITS:0]       u;
  logic [32:0]           tt_q, uu_q, ut_q;
  logic [65:0]           r_full, g_full, b_full;
  logic [63:0]           r64_q, g64_q, b64_q;
  logic [79:0]           r_col, g_col, b_col;
  logic [7:0]            red_q, green_q, blue_q;
  pixel_out_t            out_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_re_q <= CENTER_RE_RST;
      center_im_q <= CENTER_IM_RST;
      step_q      <= STEP_RST;
      limit_q     <= LIMIT_RST;
      width_q     <= WIDTH_RST;
      height_q    <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CENTER_RE:       center_re_q <= cfg_wdata_i;
        REG_CENTER_IM:       center_im_q <= cfg_wdata_i;
        REG_PIXEL_STEP:      step_q      <= cfg_wdata_i[STEP_BITS-1:0];
        REG_ITERATION_LIMIT: limit_q     <= cfg_wdata_i[CNT_BITS-1:0];
        REG_IMAGE_WIDTH:     width_q     <= cfg_wdata_i[PIX_BITS-1:0];
        REG_IMAGE_HEIGHT:    height_q    <= cfg_wdata_i[PIX_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Start point: offset from the image middle times the step, plus the center
  assign sx_prod = $signed(off_x_q) * $signed({1'b0, step_q});
  assign sy_prod = $signed(off_y_q) * $signed({1'b0, step_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      off_x_q <= {1'b0, in_data_i.pixel_x} - {2'b0, width_q[PIX_BITS-1:1]};
      off_y_q <= {1'b0, in_data_i.pixel_y} - {2'b0, height_q[PIX_BITS-1:1]};
    end
    if (cmd_i.start0) begin
      sx_q <= sx_prod;
      sy_q <= sy_prod;
    end
  end

  // Squares and cross product of the current z
  jesc_mul u_mul_xx (
    .clk_i, .pp_en_i(cmd_i.mul_pp), .sum_en_i(cmd_i.mul_sum), .fix_en_i(cmd_i.mul_fix),
    .a_i(zx_q), .b_i(zx_q), .prod_o(xx_prod)
  );
  jesc_mul u_mul_yy (
    .clk_i, .pp_en_i(cmd_i.mul_pp), .sum_en_i(cmd_i.mul_sum), .fix_en_i(cmd_i.mul_fix),
    .a_i(zy_q), .b_i(zy_q), .prod_o(yy_prod)
  );
  jesc_mul u_mul_xy (
    .clk_i, .pp_en_i(cmd_i.mul_pp), .sum_en_i(cmd_i.mul_sum), .fix_en_i(cmd_i.mul_fix),
    .a_i(zx_q), .b_i(zy_q), .prod_o(xy_prod)
  );

  // Rescale to Q3.60; the cross product keeps one more bit for the doubling
  assign xx_sh = $signed(xx_prod) >>> FRAC_BITS;
  assign yy_sh = $signed(yy_prod) >>> FRAC_BITS;
  assign xy_sh = $signed(xy_prod) >>> (FRAC_BITS - 1);
  assign xx    = sat_narrow(xx_sh);
  assign yy    = sat_narrow(yy_sh);
  assign xy    = sat_narrow(xy_sh);
  assign m2    = sat_add64(xx, yy);

  assign status_o.go_on = (m2 < FOUR) && (count_q < limit_q);
  assign status_o.black = !(count_q < limit_q);

  // Iterate z = z^2 + c
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      count_q <= '0;
    end else if (cmd_i.update) begin
      count_q <= count_q + 1'b1;
    end
    if (cmd_i.start1) begin
      zx_q <= sat_add64(center_re_q, sat_narrow({{51{sx_q[76]}}, sx_q}));
      zy_q <= sat_add64(center_im_q, sat_narrow({{51{sy_q[76]}}, sy_q}));
    end else if (cmd_i.update) begin
      zx_q <= sat_add64(sat_sub64(xx, yy), center_re_q);
      zy_q <= sat_add64(xy, center_im_q);
    end
  end

  // Restoring divider: t = count * 2^16 / limit, one quotient bit a cycle
  assign trial = {rem_q, 1'b0};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q <= count_q;
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (trial >= {1'b0, limit_q}) begin
        rem_q <= CNT_BITS'(trial - {1'b0, limit_q});
        quo_q <= {quo_q[T_BITS-2:0], 1'b1};
      end else begin
        rem_q <= trial[CNT_BITS-1:0];
        quo_q <= {quo_q[T_BITS-2:0], 1'b0};
      end
    end
  end

  // Gradient polynomials over three registered product steps
  assign u      = 17'h10000 - {1'b0, quo_q};
  assign r_full = ut_q * tt_q;
  assign g_full = ut_q * ut_q;
  assign b_full = uu_q * ut_q;
  assign r_col  = r64_q * RED_K;
  assign g_col  = g64_q * GREEN_K;
  assign b_col  = b64_q * BLUE_K;

  always_ff @(posedge clk_i) begin
    if (cmd_i.col0) begin
      tt_q <= 33'(quo_q * quo_q);
      uu_q <= 33'(u * u);
      ut_q <= 33'(u * quo_q);
    end
    if (cmd_i.col1) begin
      r64_q <= r_full[63:0];
      g64_q <= g_full[63:0];
      b64_q <= b_full[63:0];
    end
    if (cmd_i.col2) begin
      red_q   <= r_col[71:64];
      green_q <= g_col[71:64];
      blue_q  <= b_col[72:65];
    end
  end

  // Output register; black when the limit was reached
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.iteration_count <= count_q;
      out_q.red             <= status_o.black ? 8'd0 : red_q;
      out_q.green           <= status_o.black ? 8'd0 : green_q;
      out_q.blue            <= status_o.black ? 8'd0 : blue_q;
    end
  end

  assign out_data_o = out_q;

endmodule

>>> hw/rtl/jesc_ctrl.sv
// Controller: sequences start point, escape loop, divider and colour steps.
// Depends on jesc_pkg.
module jesc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  jesc_pkg::dp_status_t   status_i,
  output jesc_pkg::dp_cmd_t      cmd_o
);
  import jesc_pkg::*;

  state_e                  state_q, state_d;
  logic [DIV_CNT_BITS-1:0] div_cnt_q, div_cnt_d;
  logic                    out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d     = state_q;
    div_cnt_d   = div_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_START0;
        end
      end
      ST_START0: begin
        cmd_o.start0 = 1'b1;
        state_d      = ST_START1;
      end
      ST_START1: begin
        cmd_o.start1 = 1'b1;
        state_d      = ST_PP;
      end
      ST_PP: begin
        cmd_o.mul_pp = 1'b1;
        state_d      = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.mul_sum = 1'b1;
        state_d       = ST_FIX;
      end
      ST_FIX: begin
        cmd_o.mul_fix = 1'b1;
        state_d       = ST_TEST;
      end
      ST_TEST: begin
        priority if (status_i.go_on) begin
          cmd_o.update = 1'b1;
          state_d      = ST_PP;
        end else if (status_i.black) begin
          state_d = ST_OUT;
        end else begin
          cmd_o.div_init = 1'b1;
          div_cnt_d      = '0;
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        div_cnt_d      = div_cnt_q + 1'b1;
        if (div_cnt_q == DIV_CNT_BITS'(T_BITS - 1)) begin
          state_d = ST_COL0;
        end
      end
      ST_COL0: begin
        cmd_o.col0 = 1'b1;
        state_d    = ST_COL1;
      end
      ST_COL1: begin
        cmd_o.col1 = 1'b1;
        state_d    = ST_COL2;
      end
      ST_COL2: begin
        cmd_o.col2 = 1'b1;
        state_d    = ST_OUT;
      end
      ST_OUT: begin
        // Hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> hw/rtl/julia_escape_time_pixel_core.sv
// Julia escape-time pixel core: one pixel in, iteration count and RGB out.
// Each escape iteration runs the three 3-stage 64x64 multipliers and then the test
// step; the 16-step divider and the colour products follow when the limit is not
// reached; one pixel at a time.
// Reset: asynchronous active-low; the configuration registers return to their default view.
module julia_escape_time_pixel_core #(
  parameter int COORD_FRACTION_BITS = 60
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  jesc_pkg::pixel_in_t           in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output jesc_pkg::pixel_out_t          out_data_o,
  input  logic                          cfg_we_i,
  input  logic [jesc_pkg::IDX_BITS-1:0] cfg_idx_i,
  input  logic [63:0]                   cfg_wdata_i
);
  import jesc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  jesc_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .out_valid_o,
    .out_ready_i,
    .status_i (status),
    .cmd_o    (cmd)
  );

  jesc_datapath #(
    .FRAC_BITS (COORD_FRACTION_BITS)
  ) u_datapath (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_data_i,
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o
  );

endmodule

>>> test/julia_escape_time_pixel_core_tb.sv
// Self-checking testbench for the Julia escape-time pixel core.
// Depends on jesc_pkg and julia_escape_time_pixel_core; drives pixels, checks count and colour.
`timescale 1ns / 1ps

module julia_escape_time_pixel_core_tb;
  import jesc_pkg::*;

  localparam int FRAC       = 60;
  localparam int IDLE_LIMIT = 200000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  pixel_in_t  in_data_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  pixel_out_t out_data_o;
  logic       cfg_we_i = 1'b0;
  logic [IDX_BITS-1:0] cfg_idx_i = '0;
  logic [63:0] cfg_wdata_i = '0;

  julia_escape_time_pixel_core #(.COORD_FRACTION_BITS(FRAC)) DUT (.*);

  // Local copy of the view registers
  logic signed [63:0] view_re, view_im;
  logic [62:0]        view_step;
  logic [11:0]        view_limit, view_w, view_h;

  pixel_in_t  pixel_queue[$];
  pixel_out_t colour_queue[$];
  int  errors = 0;
  int  accepted_in = 0, checked_out = 0, escaped_px = 0, capped_px = 0;
  int  idle_cycles = 0;
  bit  stim_done = 0;
  bit  long_stall = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [63:0] clamp128(logic signed [127:0] p);
    if (p > 128'sh7FFF_FFFF_FFFF_FFFF) return S64_MAX;
    if (p < -128'sh8000_0000_0000_0000) return S64_MIN;
    return p[63:0];
  endfunction

  // Signed product shifted right with floor, then clamped
  function automatic logic [63:0] mul_shift(logic signed [63:0] a, logic signed [63:0] b,
                                            int sh);
    logic signed [127:0] p;
    p = 128'(a) * 128'(b);
    return clamp128(p >>> sh);
  endfunction

  function automatic logic [63:0] add_clamp(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    return clamp128(128'(s));
  endfunction

  function automatic logic [63:0] sub_clamp(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    return clamp128(128'(s));
  endfunction

  function automatic logic [63:0] start_point(logic [11:0] pos, logic [11:0] size,
                                              logic signed [63:0] base);
    logic signed [63:0] off;
    logic signed [127:0] p;
    off = 64'(pos) - 64'(size >> 1);
    p = 128'(off) * 128'({65'd0, view_step});
    return add_clamp(base, clamp128(p));
  endfunction

  // Iterate the escape loop and derive the gradient colour
  function automatic pixel_out_t predict_pixel(pixel_in_t px);
    logic signed [63:0] zx, zy, xx, yy, m2;
    logic [63:0]  four, nx;
    logic [11:0]  cnt;
    logic [16:0]  t, u;
    logic [127:0] prod;
    pixel_out_t   res;
    four = 64'd1 << (FRAC + 2);
    zx = start_point(px.pixel_x, view_w, view_re);
    zy = start_point(px.pixel_y, view_h, view_im);
    cnt = '0;
    forever begin
      xx = mul_shift(zx, zx, FRAC);
      yy = mul_shift(zy, zy, FRAC);
      m2 = add_clamp(xx, yy);
      if (!(m2 < $signed(four) && cnt < view_limit)) break;
      nx = add_clamp(sub_clamp(xx, yy), view_re);
      zy = add_clamp(mul_shift(zx, zy, FRAC - 1), view_im);
      zx = nx;
      cnt++;
    end
    res = '0;
    res.iteration_count = cnt;
    if (cnt < view_limit) begin
      t = 17'((32'(cnt) << 16) / view_limit);
      u = 17'd65536 - t;
      prod = 128'(64'(u) * t * t * t) * 2295;
      res.red = prod[71:64];
      prod = 128'(64'(u) * u * t * t) * 3825;
      res.green = prod[71:64];
      prod = 128'(64'(u) * u * u * t) * 4335;
      res.blue = prod[72:65];
    end
    return res;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_CENTER_RE:       view_re = val;
      REG_CENTER_IM:       view_im = val;
      REG_PIXEL_STEP:      view_step = val[62:0];
      REG_ITERATION_LIMIT: view_limit = val[11:0];
      REG_IMAGE_WIDTH:     view_w = val[11:0];
      default:             view_h = val[11:0];
    endcase
  endtask

  task automatic write_view(logic [63:0] re, logic [63:0] im, logic [63:0] stp,
                            logic [11:0] lim, logic [11:0] w, logic [11:0] h);
    write_reg(REG_CENTER_RE, re);
    write_reg(REG_CENTER_IM, im);
    write_reg(REG_PIXEL_STEP, stp);
    write_reg(REG_ITERATION_LIMIT, {52'd0, lim});
    write_reg(REG_IMAGE_WIDTH, {52'd0, w});
    write_reg(REG_IMAGE_HEIGHT, {52'd0, h});
  endtask

  // Hold until the queue drains and the core has gone quiet
  task automatic drain();
    do @(posedge clk_i);
    while (pixel_queue.size() != 0 || in_valid_i || colour_queue.size() != 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic push_pixel(logic [11:0] x, logic [11:0] y);
    pixel_in_t p;
    p.pixel_x = x;
    p.pixel_y = y;
    pixel_queue.push_back(p);
  endtask

  // Pixels mostly inside the image, a few anywhere
  task automatic push_random(int n);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) push_pixel(12'($urandom), 12'($urandom));
      else push_pixel(12'($urandom_range(0, view_w)), 12'($urandom_range(0, view_h)));
    end
  endtask

  // Note whether the offered pixel was taken at the last rising edge
  bit in_taken = 1'b0;
  always @(posedge clk_i) begin
    in_taken <= in_valid_i && in_ready_o;
  end

  // Driver: bursts of transactions with random gaps
  int burst_left = 0, gap_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_taken) begin
        // hold the offered pixel
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pixel_queue.size() > 0) begin
        in_data_i <= pixel_queue.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 30);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall pattern, with one long hold-off on request
  int stall_phase = 0, hold_cnt = 0;
  always @(negedge clk_i) begin
    stall_phase <= stall_phase + 1;
    if (long_stall && hold_cnt < 3000) begin
      hold_cnt <= hold_cnt + 1;
      out_ready_i <= 1'b0;
    end else if (stall_phase[9]) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= (stall_phase % 7 < 4) || ($urandom_range(0, 3) == 0);
    end
  end

  // Monitor: predict on input, compare on output
  always @(posedge clk_i) begin
    pixel_out_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        colour_queue.push_back(predict_pixel(in_data_i));
        accepted_in++;
      end
      if (out_valid_o && out_ready_i) begin
        checked_out++;
        if (colour_queue.size() == 0) begin
          $error("unexpected pixel result %p", out_data_o);
          errors++;
        end else begin
          want = colour_queue.pop_front();
          if (want.iteration_count == view_limit) capped_px++;
          else escaped_px++;
          if (out_data_o.iteration_count !== want.iteration_count) begin
            $error("iteration_count exp %0d got %0d", want.iteration_count,
                   out_data_o.iteration_count);
            errors++;
          end
          if (out_data_o.red !== want.red) begin
            $error("red exp %0d got %0d", want.red, out_data_o.red);
            errors++;
          end
          if (out_data_o.green !== want.green) begin
            $error("green exp %0d got %0d", want.green, out_data_o.green);
            errors++;
          end
          if (out_data_o.blue !== want.blue) begin
            $error("blue exp %0d got %0d", want.blue, out_data_o.blue);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    view_re = CENTER_RE_RST;
    view_im = CENTER_IM_RST;
    view_step = STEP_RST;
    view_limit = LIMIT_RST;
    view_w = WIDTH_RST;
    view_h = HEIGHT_RST;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: corners, center and out-of-image at reset view
    push_pixel(12'd0, 12'd0);
    push_pixel(12'd4095, 12'd4095);
    push_pixel(12'd960, 12'd540);
    push_pixel(12'd4095, 12'd0);
    push_pixel(12'd0, 12'd4095);
    push_pixel(12'hAAA, 12'h555);
    push_pixel(12'h555, 12'hAAA);
    drain();

    // Zero limit gives black, zero step puts all pixels on the center
    write_view(64'd0, 64'd0, 64'd0, 12'd0, 12'd1, 12'd1);
    push_pixel(12'd0, 12'd0);
    push_pixel(12'd4095, 12'd7);
    drain();
    write_reg(REG_ITERATION_LIMIT, 64'd4095);
    push_pixel(12'd3, 12'd3);
    drain();
    // Extreme centers and step saturate and escape at once
    write_view(S64_MAX, S64_MIN, {1'b0, {63{1'b1}}}, 12'd1, 12'd4095, 12'd4095);
    push_pixel(12'd0, 12'd4095);
    push_pixel(12'd2047, 12'd2047);
    drain();
    write_view(S64_MIN, S64_MAX, 64'd1, 12'd4095, 12'd4095, 12'd1);
    push_pixel(12'd4095, 12'd0);
    push_pixel(12'd2047, 12'd0);
    drain();

    // Random views, mostly short limits to keep the run quick
    for (int ph = 0; ph < 12; ph++) begin
      write_view(64'($signed($urandom_range(0, 1600)) - 800) <<< (FRAC - 9),
                 64'($signed($urandom_range(0, 1600)) - 800) <<< (FRAC - 9),
                 (ph == 5) ? {$urandom, $urandom} : 64'($urandom_range(1, 4000)) << 40,
                 12'($urandom_range(1, (ph % 4 == 0) ? 600 : 60)),
                 12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)));
      if (ph == 3) long_stall = 1;
      push_random(95);
      drain();
    end
    // Reset view with its default limit
    write_view(CENTER_RE_RST, CENTER_IM_RST, STEP_RST, LIMIT_RST, 12'd64, 12'd64);
    push_random(20);
    drain();

    if (colour_queue.size() != 0) begin
      $error("%0d pixel results never arrived", colour_queue.size());
      errors++;
    end
    $display("Covered %0d pixels: %0d escaped, %0d capped at the limit,", checked_out,
             escaped_px, capped_px);
    $display("across directed corner views and random views with back-pressure.");
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
